### hdl/y2r_pkg.sv
// Package with types, constants and helpers for the YCbCr to RGB converter.
package y2r_pkg;

    // Width of the signed fixed-point accumulators (16-bit fraction).
    localparam int ACC_W = 27;

    // BT.601 studio-range coefficients, scaled by 2^16.
    localparam logic signed [ACC_W-1:0] COEF_Y    = 27'sd76309;
    localparam logic signed [ACC_W-1:0] COEF_CR_R = 27'sd104597;
    localparam logic signed [ACC_W-1:0] COEF_CB_G = 27'sd25675;
    localparam logic signed [ACC_W-1:0] COEF_CR_G = 27'sd53279;
    localparam logic signed [ACC_W-1:0] COEF_CB_B = 27'sd132201;

    // Offsets removed from luma and chroma samples.
    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

    // Alpha byte value when alpha is enabled.
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_CHROMA_MODE  = 2'd0;
    localparam logic [1:0] REG_RED_FIRST    = 2'd1;
    localparam logic [1:0] REG_ALPHA_ENABLE = 2'd2;

    // Lane numbers in emission order for 4:2:0 (4:2:2 uses lanes 0 and 2).
    localparam int LANE_TL = 0;
    localparam int LANE_BL = 1;
    localparam int LANE_TR = 2;
    localparam int LANE_BR = 3;
    localparam int NUM_LANES = 4;

    // Configuration register set.
    typedef struct packed {
        logic chroma_mode;
        logic red_first;
        logic alpha_enable;
    } cfg_t;

    // One input request.
    typedef struct packed {
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [7:0] luma_top_left;
        logic [7:0] luma_top_right;
        logic [7:0] luma_bottom_left;
        logic [7:0] luma_bottom_right;
    } in_item_t;

    // One output pixel.
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [7:0] alpha_byte;
        logic       bottom_row;
        logic       last_pixel;
    } out_pixel_t;

    // Color bytes of one pixel, already in output byte order.
    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
    } rgb_t;

    // Registered chroma products shared by all lanes.
    typedef struct packed {
        logic signed [ACC_W-1:0] cr_red;
        logic signed [ACC_W-1:0] cb_green;
        logic signed [ACC_W-1:0] cr_green;
        logic signed [ACC_W-1:0] cb_blue;
    } chroma_terms_t;

    // Floor by 2^16 and saturate to 0..255.
    function automatic logic [7:0] sat8(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1]) begin
            res = 8'd0;
        end else if (|acc[ACC_W-2:24]) begin
            res = 8'hFF;
        end else begin
            res = acc[23:16];
        end
        return res;
    endfunction

endpackage

### hdl/y2r_chroma.sv
// Chroma stage: registers the four chroma products shared by the lanes.
module y2r_chroma (
    input  logic                       aclk,
    input  logic                       load,
    input  logic [7:0]                 chroma_blue,
    input  logic [7:0]                 chroma_red,
    output y2r_pkg::chroma_terms_t     terms
);

    logic signed [8:0]       dcb;
    logic signed [8:0]       dcr;
    y2r_pkg::chroma_terms_t  terms_reg;
    y2r_pkg::chroma_terms_t  terms_next;

    // Remove the chroma offset and form the four products.
    always_comb begin
        dcb = $signed({1'b0, chroma_blue}) - y2r_pkg::CHROMA_OFFSET;
        dcr = $signed({1'b0, chroma_red}) - y2r_pkg::CHROMA_OFFSET;
        terms_next.cr_red   = y2r_pkg::ACC_W'(dcr) * y2r_pkg::COEF_CR_R;
        terms_next.cb_green = y2r_pkg::ACC_W'(dcb) * y2r_pkg::COEF_CB_G;
        terms_next.cr_green = y2r_pkg::ACC_W'(dcr) * y2r_pkg::COEF_CR_G;
        terms_next.cb_blue  = y2r_pkg::ACC_W'(dcb) * y2r_pkg::COEF_CB_B;
    end

    // Products are captured when the request moves into this stage.
    always_ff @(posedge aclk) begin
        if (load) begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

### hdl/y2r_lane.sv
// One conversion lane: luma product, channel sums, saturation and byte order.
module y2r_lane (
    input  logic                    aclk,
    input  logic                    load,
    input  logic [7:0]              luma,
    input  y2r_pkg::chroma_terms_t  terms,
    input  y2r_pkg::cfg_t           cfg,
    output y2r_pkg::rgb_t           pixel
);

    logic signed [8:0]                dy;
    logic signed [y2r_pkg::ACC_W-1:0] yy_reg;
    logic signed [y2r_pkg::ACC_W-1:0] yy_next;
    logic signed [y2r_pkg::ACC_W-1:0] r_acc;
    logic signed [y2r_pkg::ACC_W-1:0] g_acc;
    logic signed [y2r_pkg::ACC_W-1:0] b_acc;
    logic [7:0]                       r_sat;
    logic [7:0]                       g_sat;
    logic [7:0]                       b_sat;

    // Scaled luma with the studio-range offset removed.
    always_comb begin
        dy      = $signed({1'b0, luma}) - y2r_pkg::LUMA_OFFSET;
        yy_next = y2r_pkg::ACC_W'(dy) * y2r_pkg::COEF_Y;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            yy_reg <= yy_next;
        end
    end

    // Channel sums from the registered luma and chroma products.
    always_comb begin
        r_acc = yy_reg + terms.cr_red;
        g_acc = yy_reg - terms.cb_green - terms.cr_green;
        b_acc = yy_reg + terms.cb_blue;
        r_sat = y2r_pkg::sat8(r_acc);
        g_sat = y2r_pkg::sat8(g_acc);
        b_sat = y2r_pkg::sat8(b_acc);
    end

    // Place red and blue according to the byte order.
    always_comb begin
        pixel.first_byte  = cfg.red_first ? r_sat : b_sat;
        pixel.second_byte = g_sat;
        pixel.third_byte  = cfg.red_first ? b_sat : r_sat;
    end

endmodule

### hdl/y2r_merge.sv
// Merge: holds a request's lane results; sends one per cycle when m_ready is high.
module y2r_merge (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        load,
    input  y2r_pkg::rgb_t [y2r_pkg::NUM_LANES-1:0]      lane_pix,
    input  y2r_pkg::cfg_t                               cfg,
    output logic                                        ready,
    output logic                                        m_valid,
    input  logic                                        m_ready,
    output y2r_pkg::out_pixel_t                         m_pixel
);

    y2r_pkg::rgb_t [y2r_pkg::NUM_LANES-1:0] pix_reg;
    logic                                   valid_reg;
    logic                                   valid_next;
    logic [1:0]                             idx_reg;
    logic [1:0]                             idx_next;
    logic                                   last;
    logic                                   take;

    // The last pixel is the bottom-right one in 4:2:0 and the right one in 4:2:2.
    assign last  = idx_reg[1] && (idx_reg[0] || !cfg.chroma_mode);
    assign take  = valid_reg && m_ready;
    assign ready = !valid_reg || (take && last);

    // Sequence through the lanes; 4:2:2 skips the bottom-row lanes.
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (take && last) begin
            valid_next = 1'b0;
            idx_next   = 2'd0;
        end else if (take) begin
            idx_next = cfg.chroma_mode ? idx_reg + 2'd1 : idx_reg + 2'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Lane results are stored as a whole request.
    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= lane_pix;
        end
    end

    // Output pixel picked from the buffer by the sequence index.
    always_comb begin
        m_pixel.first_byte  = pix_reg[idx_reg].first_byte;
        m_pixel.second_byte = pix_reg[idx_reg].second_byte;
        m_pixel.third_byte  = pix_reg[idx_reg].third_byte;
        m_pixel.alpha_byte  = cfg.alpha_enable ? y2r_pkg::ALPHA_OPAQUE : 8'd0;
        m_pixel.bottom_row  = idx_reg[0];
        m_pixel.last_pixel  = last;
    end

    assign m_valid = valid_reg;

endmodule

### hdl/ycbcr_to_rgb_pixel_converter_core.sv
// Top level of the BT.601 YCbCr to RGB pixel converter.
//
// Usage: each request on the s_ channel carries one Cb/Cr pair and four luma
// samples. In 4:2:2 mode two pixels leave on the m_ channel (left, right); in
// 4:2:0 mode four leave (top-left, bottom-left, top-right, bottom-right).
// The last pixel of each request is flagged with last_pixel.
// Path: a taken request passes the input register, the product registers and
// the merge stage's pixel buffer before its first pixel is valid.
// Throughput: one pixel per cycle while m_ready is high, set by the pixel
// buffer in the merge stage; the input and product stages keep taking
// requests while it drains.
// Stall: when m_ready is low the current pixel holds, and the pipeline
// fills up to three requests before s_ready drops.
// Reset: aresetn is synchronous and active low; it empties the pipeline and
// sets 4:2:2 mode, blue-first byte order and alpha on.
// Configuration: cfg_wr_en writes bit 0 of cfg_wdata to register cfg_index
// (0 chroma mode, 1 red first, 2 alpha enable); write only while idle.
module ycbcr_to_rgb_pixel_converter_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic                  cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  y2r_pkg::in_item_t     s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output y2r_pkg::out_pixel_t   m_pixel
);

    y2r_pkg::cfg_t                           cfg_reg;
    y2r_pkg::cfg_t                           cfg_next;
    y2r_pkg::in_item_t                       item_reg;
    logic                                    a_valid_reg;
    logic                                    a_valid_next;
    logic                                    b_valid_reg;
    logic                                    b_valid_next;
    logic                                    a_ready;
    logic                                    b_ready;
    logic                                    c_ready;
    logic                                    b_load;
    logic                                    c_load;
    y2r_pkg::chroma_terms_t                  terms;
    logic [y2r_pkg::NUM_LANES-1:0][7:0]      lane_luma;
    y2r_pkg::rgb_t [y2r_pkg::NUM_LANES-1:0]  lane_pix;

    // Configuration register writes; unknown indexes are ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                y2r_pkg::REG_CHROMA_MODE:  cfg_next.chroma_mode  = cfg_wdata;
                y2r_pkg::REG_RED_FIRST:    cfg_next.red_first    = cfg_wdata;
                y2r_pkg::REG_ALPHA_ENABLE: cfg_next.alpha_enable = cfg_wdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{chroma_mode: 1'b0, red_first: 1'b0, alpha_enable: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Ready chain through the input and product stages.
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign s_ready = a_ready;
    assign b_load  = a_valid_reg && b_ready;
    assign c_load  = b_valid_reg && c_ready;

    always_comb begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        if (s_valid && a_ready) begin
            a_valid_next = 1'b1;
        end else if (b_load) begin
            a_valid_next = 1'b0;
        end
        if (b_load) begin
            b_valid_next = 1'b1;
        end else if (c_load) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    // Input register for the accepted request.
    always_ff @(posedge aclk) begin
        if (s_valid && a_ready) begin
            item_reg <= s_item;
        end
    end

    // Chroma products shared by all lanes.
    y2r_chroma u_chroma (
        .aclk        (aclk),
        .load        (b_load),
        .chroma_blue (item_reg.chroma_blue),
        .chroma_red  (item_reg.chroma_red),
        .terms       (terms)
    );

    // Luma samples in emission order.
    assign lane_luma[y2r_pkg::LANE_TL] = item_reg.luma_top_left;
    assign lane_luma[y2r_pkg::LANE_BL] = item_reg.luma_bottom_left;
    assign lane_luma[y2r_pkg::LANE_TR] = item_reg.luma_top_right;
    assign lane_luma[y2r_pkg::LANE_BR] = item_reg.luma_bottom_right;

    // Four conversion lanes, one per luma sample.
    for (genvar i = 0; i < y2r_pkg::NUM_LANES; i++) begin : g_lane
        y2r_lane u_lane (
            .aclk  (aclk),
            .load  (b_load),
            .luma  (lane_luma[i]),
            .terms (terms),
            .cfg   (cfg_reg),
            .pixel (lane_pix[i])
        );
    end

    // Merge stage serializes the lane results onto the output channel.
    y2r_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (c_load),
        .lane_pix (lane_pix),
        .cfg      (cfg_reg),
        .ready    (c_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_pixel  (m_pixel)
    );

`ifndef SYNTH
    // A taken request always lands in the input stage.
    a_take_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> a_valid_reg)
        else $error("accepted request did not reach the input stage");

    // Packed 4:2:2 pixels always belong to the top row.
    a_422_top_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !cfg_reg.chroma_mode) |-> !m_pixel.bottom_row)
        else $error("bottom row pixel in 4:2:2 mode");

    // With nothing waiting behind it, the last pixel empties the output.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_pixel.last_pixel && !b_valid_reg) |=> !m_valid)
        else $error("output stayed valid after its last pixel");

    // A product stage request moves on as soon as the output frees up.
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && m_valid && m_ready && m_pixel.last_pixel) |=> m_valid)
        else $error("queued request was not moved to the output");
`endif

endmodule

### tb/ycbcr_to_rgb_pixel_converter_core_tb.sv
// Self-checking testbench for the BT.601 YCbCr to RGB pixel converter core.
module ycbcr_to_rgb_pixel_converter_core_tb;

    // Fixed-point coefficients of the conversion, scaled by 2^16.
    localparam int LUMA_GAIN     = 76309;
    localparam int CR_TO_RED     = 104597;
    localparam int CB_TO_GREEN   = 25675;
    localparam int CR_TO_GREEN   = 53279;
    localparam int CB_TO_BLUE    = 132201;
    localparam int LUMA_BLACK    = 16;
    localparam int CHROMA_ZERO   = 128;

    // Index past the last register; writes to it must have no effect.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 10;
    localparam int LONG_HOLD      = 300;
    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 50;
    localparam int CYCLE_LIMIT    = 400000;

    // Scoreboard: predicts pixels per request and checks them in order.
    class pixel_scoreboard;
        y2r_pkg::cfg_t        regs;
        y2r_pkg::out_pixel_t  expected_pixels[$];
        int unsigned          mismatches;
        int unsigned          requests_seen;
        int unsigned          pixels_seen;

        function new();
            regs.chroma_mode  = 1'b0;
            regs.red_first    = 1'b0;
            regs.alpha_enable = 1'b1;
            mismatches        = 0;
            requests_seen     = 0;
            pixels_seen       = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic value);
            unique case (index)
                y2r_pkg::REG_CHROMA_MODE:  regs.chroma_mode  = value;
                y2r_pkg::REG_RED_FIRST:    regs.red_first    = value;
                y2r_pkg::REG_ALPHA_ENABLE: regs.alpha_enable = value;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // Floor by 2^16, then clamp to a byte.
        function logic [7:0] clamp_channel(int acc);
            int shifted;
            if (acc < 0) begin
                return 8'd0;
            end
            shifted = acc >>> 16;
            return (shifted > 255) ? 8'hFF : shifted[7:0];
        endfunction

        function void predict_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                                    logic bottom, logic last);
            int                  luma_term;
            int                  cb_delta;
            int                  cr_delta;
            logic [7:0]          red;
            logic [7:0]          green;
            logic [7:0]          blue;
            y2r_pkg::out_pixel_t px;
            luma_term = LUMA_GAIN * (int'(luma) - LUMA_BLACK);
            cb_delta  = int'(cb) - CHROMA_ZERO;
            cr_delta  = int'(cr) - CHROMA_ZERO;
            red   = clamp_channel(luma_term + CR_TO_RED * cr_delta);
            green = clamp_channel(luma_term - CB_TO_GREEN * cb_delta
                                  - CR_TO_GREEN * cr_delta);
            blue  = clamp_channel(luma_term + CB_TO_BLUE * cb_delta);
            px.first_byte  = regs.red_first ? red : blue;
            px.second_byte = green;
            px.third_byte  = regs.red_first ? blue : red;
            px.alpha_byte  = regs.alpha_enable ? 8'hFF : 8'h00;
            px.bottom_row  = bottom;
            px.last_pixel  = last;
            expected_pixels.push_back(px);
        endfunction

        // An accepted request yields two pixels in 4:2:2 and a 2x2 block in 4:2:0.
        function void note_request(y2r_pkg::in_item_t req);
            requests_seen++;
            if (regs.chroma_mode) begin
                predict_pixel(req.luma_top_left, req.chroma_blue, req.chroma_red,
                              1'b0, 1'b0);
                predict_pixel(req.luma_bottom_left, req.chroma_blue, req.chroma_red,
                              1'b1, 1'b0);
                predict_pixel(req.luma_top_right, req.chroma_blue, req.chroma_red,
                              1'b0, 1'b0);
                predict_pixel(req.luma_bottom_right, req.chroma_blue, req.chroma_red,
                              1'b1, 1'b1);
            end else begin
                predict_pixel(req.luma_top_left, req.chroma_blue, req.chroma_red,
                              1'b0, 1'b0);
                predict_pixel(req.luma_top_right, req.chroma_blue, req.chroma_red,
                              1'b0, 1'b1);
            end
        endfunction

        function void compare_field(string name, int unsigned exp_val,
                                    int unsigned act_val);
            if (exp_val != act_val) begin
                $error("%s expected %0d actual %0d", name, exp_val, act_val);
                mismatches++;
            end
        endfunction

        function void check_pixel(y2r_pkg::out_pixel_t got);
            y2r_pkg::out_pixel_t exp_px;
            pixels_seen++;
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel %h with no request outstanding", got);
                mismatches++;
                return;
            end
            exp_px = expected_pixels.pop_front();
            compare_field("first_byte",  32'(exp_px.first_byte),  32'(got.first_byte));
            compare_field("second_byte", 32'(exp_px.second_byte), 32'(got.second_byte));
            compare_field("third_byte",  32'(exp_px.third_byte),  32'(got.third_byte));
            compare_field("alpha_byte",  32'(exp_px.alpha_byte),  32'(got.alpha_byte));
            compare_field("bottom_row",  32'(exp_px.bottom_row),  32'(got.bottom_row));
            compare_field("last_pixel",  32'(exp_px.last_pixel),  32'(got.last_pixel));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [1:0]           cfg_index;
    logic                 cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    y2r_pkg::in_item_t    s_item;
    logic                 m_valid;
    logic                 m_ready;
    y2r_pkg::out_pixel_t  m_pixel;

    pixel_scoreboard sb;
    int unsigned     sender_idle_pct;
    int unsigned     receiver_idle_pct;
    logic            long_hold_pending;
    int unsigned     long_hold_left;
    int unsigned     cycle_count;
    int unsigned     settings_used;

    ycbcr_to_rgb_pixel_converter_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pixel   (m_pixel)
    );

    always #CLK_HALF aclk = ~aclk;

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: check each accepted pixel, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pixel(m_pixel);
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            m_ready <= 1'b0;
        end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            long_hold_left    = LONG_HOLD;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic y2r_pkg::in_item_t make_request(logic [7:0] cb, logic [7:0] cr,
                                                       logic [7:0] tl, logic [7:0] tr,
                                                       logic [7:0] bl, logic [7:0] br);
        y2r_pkg::in_item_t req;
        req.chroma_blue       = cb;
        req.chroma_red        = cr;
        req.luma_top_left     = tl;
        req.luma_top_right    = tr;
        req.luma_bottom_left  = bl;
        req.luma_bottom_right = br;
        return req;
    endfunction

    // Mostly uniform samples, with extra weight on the range limits.
    function automatic logic [7:0] random_sample();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(15));
            3:       return 8'($urandom_range(255, 236));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Offer one request, with optional idle cycles ahead of it.
    task automatic send_request(y2r_pkg::in_item_t req);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_request(req);
    endtask

    // Let every expected pixel come out, then give the pipeline time to settle.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(index, value);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(logic mode, logic red, logic alpha);
        write_reg(y2r_pkg::REG_CHROMA_MODE, mode);
        write_reg(y2r_pkg::REG_RED_FIRST, red);
        write_reg(y2r_pkg::REG_ALPHA_ENABLE, alpha);
        write_reg(REG_UNUSED, 1'($urandom_range(1)));
        settings_used++;
    endtask

    initial begin
        logic [2:0]        phase_setting [PHASES];
        y2r_pkg::in_item_t req;

        phase_setting = '{3'b000, 3'b111, 3'b101, 3'b010, 3'b110, 3'b001};
        sb                = new();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        long_hold_pending = 1'b0;
        long_hold_left    = 0;
        cycle_count       = 0;
        settings_used     = 1;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= y2r_pkg::REG_CHROMA_MODE;
        cfg_wdata <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        m_ready   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset setting: 4:2:2, blue first, alpha on.
        send_request(make_request(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(8'd128, 8'd128, 8'd16, 8'd16, 8'd16, 8'd16));
        send_request(make_request(8'd128, 8'd128, 8'd235, 8'd235, 8'd235, 8'd235));
        send_request(make_request(8'hFF, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128));
        send_request(make_request(8'd0, 8'hFF, 8'd128, 8'd128, 8'd128, 8'd128));
        // Bottom lumas must be ignored in packed mode.
        send_request(make_request(8'd128, 8'd128, 8'd0, 8'd40, 8'hFF, 8'hAA));
        wait_until_drained();

        // Opposite extreme: 4:2:0, red first, alpha off.
        apply_setting(1'b1, 1'b1, 1'b0);
        send_request(make_request(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_request(make_request(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_request(8'd128, 8'd128, 8'd0, 8'd85, 8'd170, 8'hFF));
        send_request(make_request(8'hFF, 8'hFF, 8'd16, 8'd235, 8'd100, 8'd200));
        send_request(make_request(8'd0, 8'd0, 8'd235, 8'd16, 8'd200, 8'd100));
        send_request(make_request(8'hFF, 8'd0, 8'd60, 8'd90, 8'd120, 8'd150));
        send_request(make_request(8'd0, 8'hFF, 8'd60, 8'd90, 8'd120, 8'd150));
        send_request(make_request(8'h55, 8'hAA, 8'hAA, 8'h55, 8'h0F, 8'hF0));
        wait_until_drained();

        // Random traffic over several settings and idle mixes.
        for (int phase = 0; phase < PHASES; phase++) begin
            apply_setting(phase_setting[phase][2], phase_setting[phase][1],
                          phase_setting[phase][0]);
            if (phase < 2) begin
                sender_idle_pct   = 12;
                receiver_idle_pct = 74;
            end else if (phase < 4) begin
                sender_idle_pct   = 74;
                receiver_idle_pct = 12;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            // Hold the output off for a long stretch so the input backs up.
            if (phase == 4) begin
                long_hold_pending = 1'b1;
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                req = make_request(random_sample(), random_sample(), random_sample(),
                                   random_sample(), random_sample(), random_sample());
                send_request(req);
            end
            wait_until_drained();
        end

        sb.mismatches += sb.pending();
        $display("Converted %0d requests into %0d pixels across %0d register settings,",
                 sb.requests_seen, sb.pixels_seen, settings_used);
        $display("with both chroma modes, byte orders and alpha states under mixed stalls.");
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### ycbcr_to_rgb_pixel_converter_core.f
hdl/y2r_pkg.sv
hdl/y2r_chroma.sv
hdl/y2r_lane.sv
hdl/y2r_merge.sv
hdl/ycbcr_to_rgb_pixel_converter_core.sv
tb/ycbcr_to_rgb_pixel_converter_core_tb.sv
